/* design/assert_macros.svh */
// assertion macros shared by the brdf evaluator modules
// expects clk_i and rst_ni in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PBE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pbe_pkg.sv */
// types, constants and table functions of the phong brdf evaluator
// no dependencies
`default_nettype none

package pbe_pkg;

  localparam int unsigned LogTableDepth = 256;
  localparam int unsigned ExpTableDepth = 256;

  localparam logic [30:0] INV_PI_Q32  = 31'd1367130551;
  localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
  localparam logic [23:0] OUT_MAX     = 24'hFFFFFF;
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [15:0] SHINE_RESET = 16'd256;

  typedef enum logic [2:0] {
    REG_DIFF_R  = 3'd0,
    REG_DIFF_G  = 3'd1,
    REG_DIFF_B  = 3'd2,
    REG_SPEC_R  = 3'd3,
    REG_SPEC_G  = 3'd4,
    REG_SPEC_B  = 3'd5,
    REG_SHINE   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][15:0] kd;
    logic [2:0][15:0] ks;
    logic [15:0]      shine;
  } cfg_t;

  typedef struct packed {
    logic [2:0][15:0] in_dir;
    logic [2:0][15:0] out_dir;
    logic [2:0][15:0] normal;
  } item_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] rem;
    res = '0;
    rem = v;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > rem) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // log2 of 1 + x0 / 2^30, by repeated squaring, q.16
  function automatic logic [16:0] log_value(input logic [63:0] x0);
    logic [63:0] x;
    logic [63:0] acc;
    x = 64'h4000_0000 + x0;
    acc = '0;
    for (int k = 0; k < 20; k++) begin
      x = (x * x) >> 30;
      acc = acc << 1;
      if (x >= 64'h8000_0000) begin
        acc = acc | 64'd1;
        x = x >> 1;
      end
    end
    return 17'((acc + 64'd8) >> 4);
  endfunction

  // 2^-(g / 2^20), product of nested square roots, q.16
  function automatic logic [16:0] exp_value(input logic [63:0] g);
    logic [63:0] r;
    logic [63:0] p;
    r = isqrt64(64'h8000_0000_0000_0000);
    p = 64'h1_0000_0000;
    for (int k = 1; k <= 20; k++) begin
      if (g[20-k]) p = (p * r) >> 32;
      r = isqrt64(r << 32);
    end
    return 17'((p + 64'd32768) >> 16);
  endfunction

endpackage

`default_nettype wire

/* design/pbe_if.sv */
// channel interfaces of the phong brdf evaluator: items, results, register writes
// no dependencies
`default_nettype none

interface pbe_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_dir_x;
  logic signed [15:0] in_dir_y;
  logic signed [15:0] in_dir_z;
  logic signed [15:0] out_dir_x;
  logic signed [15:0] out_dir_y;
  logic signed [15:0] out_dir_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  modport source (output valid, in_dir_x, in_dir_y, in_dir_z, out_dir_x, out_dir_y,
                  out_dir_z, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, in_dir_x, in_dir_y, in_dir_z, out_dir_x, out_dir_y,
                out_dir_z, normal_x, normal_y, normal_z, output ready);
endinterface

interface pbe_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] reflect_red;
  logic [23:0] reflect_green;
  logic [23:0] reflect_blue;
  modport source (output valid, reflect_red, reflect_green, reflect_blue, input ready);
  modport sink (input valid, reflect_red, reflect_green, reflect_blue, output ready);
endinterface

interface pbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/pbe_geom.sv */
// vector stages: reflection about the normal and clamped cosine c, q1.16
// depends on pbe_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pbe_geom (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire pbe_pkg::item_t item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [16:0]         cos_o
);

  localparam int NS = 6;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic signed [16:0] wo_q [3][4];
  logic signed [16:0] wi_q [3][3];
  logic signed [15:0] n_q  [3][2];
  logic signed [32:0] p0_q [3];
  logic signed [18:0] d14_q;
  logic signed [34:0] t_q  [3];
  logic signed [35:0] r_q  [3];
  logic signed [52:0] pr_q [3];
  logic [16:0]        c_q;

  logic signed [16:0] wo_d [3];
  logic signed [16:0] wi_d [3];
  logic signed [34:0] dsum;
  logic [34:0]        dmag;
  logic signed [18:0] dtr;
  logic signed [54:0] dot;
  logic [54:0]        mag;
  logic [28:0]        craw;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign cos_o       = c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wo_d[j] = -17'($signed(item_i.in_dir[j]));
      wi_d[j] = -17'($signed(item_i.out_dir[j]));
    end
    dsum = 35'(p0_q[0]) + 35'(p0_q[1]) + 35'(p0_q[2]);
    dmag = dsum[34] ? 35'(-dsum) : 35'(dsum);
    dtr  = 19'(dmag >> 14);
    dot  = 55'(pr_q[0]) + 55'(pr_q[1]) + 55'(pr_q[2]);
    mag  = dot[54] ? 55'(-dot) : 55'(dot);
    craw = mag[54:26];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        wo_q[j][0] <= wo_d[j];
        wi_q[j][0] <= wi_d[j];
        n_q[j][0]  <= $signed(item_i.normal[j]);
        p0_q[j]    <= 33'(wi_d[j]) * 33'($signed(item_i.normal[j]));
      end
    end
    if (en[1]) begin
      d14_q <= dsum[34] ? -dtr : dtr;
      for (int j = 0; j < 3; j++) begin
        wo_q[j][1] <= wo_q[j][0];
        wi_q[j][1] <= wi_q[j][0];
        n_q[j][1]  <= n_q[j][0];
      end
    end
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        t_q[j]     <= 35'(d14_q) * 35'(n_q[j][1]);
        wo_q[j][2] <= wo_q[j][1];
        wi_q[j][2] <= wi_q[j][1];
      end
    end
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        r_q[j]     <= (36'(t_q[j]) <<< 1) - (36'(wi_q[j][2]) <<< 14);
        wo_q[j][3] <= wo_q[j][2];
      end
    end
    if (en[4]) begin
      for (int j = 0; j < 3; j++) pr_q[j] <= 53'(r_q[j]) * 53'(wo_q[j][3]);
    end
    if (en[5]) begin
      c_q <= (craw > 29'(pbe_pkg::ONE_Q16)) ? pbe_pkg::ONE_Q16 : craw[16:0];
    end
  end

  `PBE_ASSERT_IMP(a_cos_bound, v_q[NS-1], c_q <= pbe_pkg::ONE_Q16, "cosine above one")

endmodule

`default_nettype wire

/* design/pbe_pow.sv */
// power stages: c^s as exp2(-s * -log2 c) through log and exp tables
// depends on pbe_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pbe_pow #(
  parameter int unsigned LOG_TABLE_DEPTH = pbe_pkg::LogTableDepth,
  parameter int unsigned EXP_TABLE_DEPTH = pbe_pkg::ExpTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] shine_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [16:0] cos_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [16:0]      pow_o
);

  localparam int NS     = 5;
  localparam int LW     = $clog2(LOG_TABLE_DEPTH);
  localparam int LDW    = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int LPW    = 15 + LDW;
  localparam int EW     = $clog2(EXP_TABLE_DEPTH);
  localparam int EDW    = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int EPW    = 16 + EDW;

  logic [16:0] log_rom [LOG_TABLE_DEPTH];
  logic [16:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_log
    localparam logic [63:0] X0 = (64'(g) << 30) / LOG_TABLE_DEPTH;
    assign log_rom[g] = pbe_pkg::log_value(X0);
  end

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    localparam logic [63:0] G0 = (64'(g) << 20) / EXP_TABLE_DEPTH;
    assign exp_rom[g] = pbe_pkg::exp_value(G0);
  end

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic [3:0]    zero_q;
  logic [3:0]    full_q;
  logic [4:0]    k_q;
  logic [LW-1:0] lidx_q;
  logic [20:0]   l_q;
  logic [28:0]   e_q;
  logic [4:0]    qs_q;
  logic          big_q;
  logic [EW-1:0] eidx_q;
  logic [16:0]   pow_q;

  logic [3:0]     msb;
  logic [15:0]    norm;
  logic [LPW-1:0] lprod;
  logic [36:0]    sprod;
  logic [EPW-1:0] eprod;
  logic [16:0]    pow_d;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign pow_o       = pow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (cos_i[i]) msb = 4'(i);
    end
    norm  = cos_i[15:0] << (4'd15 - msb);
    lprod = LPW'(norm[14:0]) * LPW'(LOG_TABLE_DEPTH);
    sprod = 37'(shine_i) * 37'(l_q);
    eprod = EPW'(e_q[15:0]) * EPW'(EXP_TABLE_DEPTH);
    if (zero_q[3]) begin
      pow_d = (shine_i == 16'd0) ? pbe_pkg::ONE_Q16 : 17'd0;
    end else if (full_q[3]) begin
      pow_d = pbe_pkg::ONE_Q16;
    end else if (big_q) begin
      pow_d = 17'd0;
    end else begin
      pow_d = exp_rom[eidx_q] >> qs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      zero_q[0] <= (cos_i == 17'd0);
      full_q[0] <= cos_i[16];
      k_q       <= 5'd16 - 5'(msb);
      lidx_q    <= lprod[15 +: LW];
    end
    if (en[1]) begin
      zero_q[1] <= zero_q[0];
      full_q[1] <= full_q[0];
      l_q       <= {k_q, 16'd0} - 21'(log_rom[lidx_q]);
    end
    if (en[2]) begin
      zero_q[2] <= zero_q[1];
      full_q[2] <= full_q[1];
      e_q       <= sprod[36:8];
    end
    if (en[3]) begin
      zero_q[3] <= zero_q[2];
      full_q[3] <= full_q[2];
      qs_q      <= e_q[20:16];
      big_q     <= |e_q[28:21];
      eidx_q    <= eprod[16 +: EW];
    end
    if (en[4]) begin
      pow_q <= pow_d;
    end
  end

  `PBE_ASSERT_IMP(a_pow_bound, v_q[NS-1], pow_q <= pbe_pkg::ONE_Q16, "power above one")
  `PBE_ASSERT_NEXT(a_zero_cos, v_q[3] && en[4] && zero_q[3] && shine_i != 16'd0,
                   pow_q == 17'd0, "zero cosine gave nonzero power")

endmodule

`default_nettype wire

/* design/pbe_shade.sv */
// color stages: diffuse and specular terms per channel, saturating sum
// depends on pbe_pkg
`default_nettype none

module pbe_shade (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pbe_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [16:0]   pow_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [2:0][23:0]   color_o
);

  localparam int NS = 3;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic [14:0] dif_q [3];
  logic [24:0] a_q   [3];
  logic [25:0] b_q   [3];
  logic [23:0] sp_q  [3];
  logic [2:0][23:0] col_q;

  logic [46:0] dprod [3];
  logic [32:0] aprod [3];
  logic [41:0] bprod [3];
  logic [55:0] sprod [3];
  logic [24:0] sum   [3];

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign color_o     = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dprod[j] = 47'(cfg_i.kd[j]) * 47'(pbe_pkg::INV_PI_Q32);
      aprod[j] = 33'(cfg_i.ks[j]) * (33'(cfg_i.shine) + 33'd512);
      bprod[j] = 42'(a_q[j]) * 42'(pow_i);
      sprod[j] = 56'(b_q[j]) * 56'(pbe_pkg::INV_2PI_Q32);
      sum[j]   = 25'(dif_q[j]) + 25'(sp_q[j]);
    end
  end

  // register-derived factors, settled long before an item gets here
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      dif_q[j] <= dprod[j][46:32];
      a_q[j]   <= aprod[j][32:8];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (en[0]) b_q[j] <= bprod[j][41:16];
      if (en[1]) sp_q[j] <= sprod[j][55:32];
      if (en[2]) col_q[j] <= sum[j][24] ? pbe_pkg::OUT_MAX : sum[j][23:0];
    end
  end

endmodule

`default_nettype wire

/* design/phong_brdf_evaluate.sv */
// top level of the phong brdf evaluator: register file and pipeline chain
// depends on pbe_pkg, pbe_if, pbe_geom, pbe_pow, pbe_shade, assert_macros.svh
//
// req_i takes one item per transfer: incoming and outgoing directions and
// the surface normal, Q1.14. rsp_o gives one result per item, in order:
// red, green and blue brdf values, Q8.16, saturated at the top code.
// cfg_i writes the seven color and shininess registers; ready is always
// high and a write to an unused index is dropped. Write them only while
// no item is in flight.
// Items from req_i to rsp_o pass six vector stages, five power stages and
// three color stages. Throughput is one item per cycle while rsp_o is not
// stalled; each stage holds one item with its own valid bit.
// When rsp_o is stalled the stages fill up behind the output register and
// req_i.ready falls only once every stage holds an item.
// Reset clears all valid bits and sets kd and ks to zero, shininess to 1.0.
`default_nettype none
`include "assert_macros.svh"

module phong_brdf_evaluate #(
  parameter int unsigned LOG_TABLE_DEPTH = pbe_pkg::LogTableDepth,
  parameter int unsigned EXP_TABLE_DEPTH = pbe_pkg::ExpTableDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pbe_in_if.sink    req_i,
  pbe_out_if.source rsp_o,
  pbe_cfg_if.sink   cfg_i
);

  pbe_pkg::cfg_t  cfg_q;
  pbe_pkg::cfg_t  cfg_d;
  pbe_pkg::item_t item;

  logic        g_valid;
  logic        g_ready;
  logic [16:0] cos;
  logic        p_valid;
  logic        p_ready;
  logic [16:0] pow;
  logic [2:0][23:0] color;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (pbe_pkg::cfg_reg_e'(cfg_i.index))
        pbe_pkg::REG_DIFF_R: cfg_d.kd[0] = cfg_i.data;
        pbe_pkg::REG_DIFF_G: cfg_d.kd[1] = cfg_i.data;
        pbe_pkg::REG_DIFF_B: cfg_d.kd[2] = cfg_i.data;
        pbe_pkg::REG_SPEC_R: cfg_d.ks[0] = cfg_i.data;
        pbe_pkg::REG_SPEC_G: cfg_d.ks[1] = cfg_i.data;
        pbe_pkg::REG_SPEC_B: cfg_d.ks[2] = cfg_i.data;
        pbe_pkg::REG_SHINE:  cfg_d.shine = cfg_i.data;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{kd: '0, ks: '0, shine: pbe_pkg::SHINE_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign item.in_dir  = {req_i.in_dir_z, req_i.in_dir_y, req_i.in_dir_x};
  assign item.out_dir = {req_i.out_dir_z, req_i.out_dir_y, req_i.out_dir_x};
  assign item.normal  = {req_i.normal_z, req_i.normal_y, req_i.normal_x};

  pbe_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .item_i      (item),
    .out_valid_o (g_valid),
    .out_ready_i (g_ready),
    .cos_o       (cos)
  );

  pbe_pow #(
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_pow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shine_i     (cfg_q.shine),
    .in_valid_i  (g_valid),
    .in_ready_o  (g_ready),
    .cos_i       (cos),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .pow_o       (pow)
  );

  pbe_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .pow_i       (pow),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .color_o     (color)
  );

  assign rsp_o.reflect_red   = color[0];
  assign rsp_o.reflect_green = color[1];
  assign rsp_o.reflect_blue  = color[2];

  `PBE_ASSERT_IMP(a_stall_needs_result, !req_i.ready, rsp_o.valid && !rsp_o.ready,
                  "input stalled without a blocked result")

endmodule

`default_nettype wire

/* dv/tb_phong_brdf_evaluate.sv */
// self-checking testbench of the phong brdf evaluator: directed and random rays,
// register settings, idle and stall phases; depends on pbe_pkg, pbe_if and the rtl
`default_nettype none

module tb_phong_brdf_evaluate;

  typedef struct packed {
    logic [23:0] red;
    logic [23:0] green;
    logic [23:0] blue;
  } color_t;

  logic clk_i;
  logic rst_ni;

  pbe_in_if  req_if ();
  pbe_out_if rsp_if ();
  pbe_cfg_if cfg_if ();

  phong_brdf_evaluate i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  logic [63:0] log_tab [pbe_pkg::LogTableDepth];
  logic [63:0] exp_tab [pbe_pkg::ExpTableDepth];
  logic [15:0] kd_reg [3];
  logic [15:0] ks_reg [3];
  logic [15:0] shine_reg;
  color_t      brdf_queue [$];
  int          mismatch_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  // table contents built independently of the package functions
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic build_tables();
    logic [63:0] roots [21];
    logic [63:0] x, acc, g, p;
    roots[1] = int_sqrt(64'h8000_0000_0000_0000);
    for (int k = 2; k <= 20; k++) roots[k] = int_sqrt(roots[k-1] << 32);
    for (int i = 0; i < pbe_pkg::LogTableDepth; i++) begin
      x = 64'h4000_0000 + ((64'(i) << 30) / pbe_pkg::LogTableDepth);
      acc = 0;
      for (int k = 0; k < 20; k++) begin
        x = (x * x) >> 30;
        acc = acc << 1;
        if (x >= 64'h8000_0000) begin
          acc = acc | 1;
          x = x >> 1;
        end
      end
      log_tab[i] = (acc + 8) >> 4;
    end
    for (int i = 0; i < pbe_pkg::ExpTableDepth; i++) begin
      g = (64'(i) << 20) / pbe_pkg::ExpTableDepth;
      p = 64'h1_0000_0000;
      for (int k = 1; k <= 20; k++) if (g[20-k]) p = (p * roots[k]) >> 32;
      exp_tab[i] = (p + 32768) >> 16;
    end
  endtask

  function automatic logic [63:0] cos_power(input logic [63:0] c, input logic [63:0] s);
    int          p;
    logic [63:0] frac, lg, e, q, f;
    if (c == 0) return (s == 0) ? 64'd65536 : 64'd0;
    if (c >= 65536) return 64'd65536;
    p = 15;
    while (c[p] == 1'b0) p--;
    frac = (c << (15 - p)) & 64'h7FFF;
    lg = (64'(16 - p) << 16) - log_tab[(frac * pbe_pkg::LogTableDepth) >> 15];
    e = (s * lg) >> 8;
    q = e >> 16;
    f = e & 64'hFFFF;
    if (q >= 32) return 64'd0;
    return exp_tab[(f * pbe_pkg::ExpTableDepth) >> 16] >> q;
  endfunction

  function automatic logic [23:0] channel_brdf(input logic [63:0] kd, input logic [63:0] ks,
                                                input logic [63:0] s, input logic [63:0] pw);
    logic [63:0] dif, a, b, sp, sum;
    dif = (kd * 64'd1367130551) >> 32;
    a = (ks * (s + 512)) >> 8;
    b = (a * pw) >> 16;
    sp = (b * 64'd683565276) >> 32;
    sum = dif + sp;
    return (sum > 64'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
  endfunction

  function automatic color_t predict_brdf(input pbe_pkg::item_t it);
    longint wo [3], wi [3], n [3];
    longint d, d14, dot, r;
    logic [63:0] mag, c, pw;
    color_t res;
    d = 0;
    dot = 0;
    for (int j = 0; j < 3; j++) begin
      wo[j] = -longint'($signed(it.in_dir[j]));
      wi[j] = -longint'($signed(it.out_dir[j]));
      n[j] = longint'($signed(it.normal[j]));
      d += n[j] * wi[j];
    end
    d14 = (d >= 0) ? (d >>> 14) : -((-d) >>> 14);
    for (int j = 0; j < 3; j++) begin
      r = 2 * d14 * n[j] - wi[j] * 16384;
      dot += r * wo[j];
    end
    mag = (dot >= 0) ? dot : -dot;
    c = mag >> 26;
    if (c > 65536) c = 65536;
    pw = cos_power(c, shine_reg);
    res.red   = channel_brdf(kd_reg[0], ks_reg[0], shine_reg, pw);
    res.green = channel_brdf(kd_reg[1], ks_reg[1], shine_reg, pw);
    res.blue  = channel_brdf(kd_reg[2], ks_reg[2], shine_reg, pw);
    return res;
  endfunction

  // item fields: index 0 is x
  task automatic send_ray(input pbe_pkg::item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.in_dir_x  <= it.in_dir[0];
    req_if.in_dir_y  <= it.in_dir[1];
    req_if.in_dir_z  <= it.in_dir[2];
    req_if.out_dir_x <= it.out_dir[0];
    req_if.out_dir_y <= it.out_dir[1];
    req_if.out_dir_z <= it.out_dir[2];
    req_if.normal_x  <= it.normal[0];
    req_if.normal_y  <= it.normal[1];
    req_if.normal_z  <= it.normal[2];
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    brdf_queue.push_back(predict_brdf(it));
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  task automatic drain_pipe();
    int guard;
    guard = 0;
    while (brdf_queue.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= 200000) begin
      $display("FAILURE");
      $finish;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input pbe_pkg::cfg_reg_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      pbe_pkg::REG_DIFF_R: kd_reg[0] = value;
      pbe_pkg::REG_DIFF_G: kd_reg[1] = value;
      pbe_pkg::REG_DIFF_B: kd_reg[2] = value;
      pbe_pkg::REG_SPEC_R: ks_reg[0] = value;
      pbe_pkg::REG_SPEC_G: ks_reg[1] = value;
      pbe_pkg::REG_SPEC_B: ks_reg[2] = value;
      pbe_pkg::REG_SHINE:  shine_reg = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_unused_index();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= 3'd7;
    cfg_if.data  <= 16'(($urandom));
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_material(input logic [15:0] kd, input logic [15:0] ks,
                              input logic [15:0] s);
    write_reg(pbe_pkg::REG_DIFF_R, kd);
    write_reg(pbe_pkg::REG_DIFF_G, kd ^ 16'h5A5A);
    write_reg(pbe_pkg::REG_DIFF_B, ~kd);
    write_reg(pbe_pkg::REG_SPEC_R, ks);
    write_reg(pbe_pkg::REG_SPEC_G, ks ^ 16'hA5A5);
    write_reg(pbe_pkg::REG_SPEC_B, ~ks);
    write_reg(pbe_pkg::REG_SHINE, s);
  endtask

  function automatic logic [15:0] unit_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // random vector: each component in [-1, 1] shifted right by 0 to 2 bits; one mode in ten is fully random
  function automatic pbe_pkg::item_t random_ray();
    pbe_pkg::item_t it;
    int mode;
    mode = $urandom_range(9);
    for (int j = 0; j < 3; j++) begin
      if (mode == 0) begin
        it.in_dir[j] = 16'($urandom);
        it.out_dir[j] = 16'($urandom);
        it.normal[j] = 16'($urandom);
      end else begin
        it.in_dir[j] = $signed(unit_comp()) >>> $urandom_range(2);
        it.out_dir[j] = $signed(unit_comp()) >>> $urandom_range(2);
        it.normal[j] = $signed(unit_comp()) >>> $urandom_range(2);
      end
    end
    return it;
  endfunction

  function automatic pbe_pkg::item_t axis_ray(input logic [15:0] ix, input logic [15:0] ox,
                                              input logic [15:0] nz);
    pbe_pkg::item_t it;
    it = '0;
    it.in_dir[2] = ix;
    it.out_dir[2] = ox;
    it.normal[2] = nz;
    return it;
  endfunction

  task automatic test_directed();
    pbe_pkg::item_t it;
    set_material(16'hFFFF, 16'hFFFF, 16'd256);
    send_ray(axis_ray(16'sd16384, -16'sd16384, 16'sd16384));
    send_ray(axis_ray(-16'sd16384, 16'sd16384, -16'sd16384));
    it = '0;
    it.in_dir[0] = 16'sd16384;
    it.out_dir[2] = 16'sd16384;
    it.normal[2] = 16'sd16384;
    send_ray(it);
    send_ray('0);
    send_ray('1);
    it = '0;
    it.in_dir = {3{16'h8000}};
    it.out_dir = {3{16'h7FFF}};
    it.normal = {3{16'h8000}};
    send_ray(it);
    send_ray({9{16'h7FFF}});
    send_ray({9{16'h8000}});
    for (int i = 0; i < 6; i++) send_ray(random_ray());
    end_burst();
    drain_pipe();
    set_material(16'd0, 16'hFFFF, 16'd0);
    send_ray('0);
    it = '0;
    it.in_dir[0] = 16'sd16384;
    it.out_dir[2] = 16'sd16384;
    it.normal[2] = 16'sd16384;
    send_ray(it);
    send_ray(axis_ray(16'sd16384, -16'sd16384, 16'sd16384));
    end_burst();
    drain_pipe();
    write_unused_index();
    set_material(16'h8000, 16'hFFFF, 16'hFFFF);
    send_ray('0);
    for (int i = 0; i < 5; i++) send_ray(random_ray());
    send_ray(axis_ray(16'sd16384, -16'sd16384, 16'sd16384));
    end_burst();
    drain_pipe();
  endtask

  task automatic random_phase(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    set_material(16'($urandom), 16'($urandom),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096)));
    for (int i = 0; i < count; i++) send_ray(random_ray());
    end_burst();
    drain_pipe();
  endtask

  task automatic test_random();
    random_phase(300, 0, 0);
    random_phase(300, 83, 0);
    random_phase(300, 0, 83);
    random_phase(300, 30, 30);
    random_phase(200, 0, 0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 60;
    for (int i = 0; i < 60; i++) send_ray(random_ray());
    end_burst();
    drain_pipe();
  endtask

  // result consumer with random stalls and an optional long hold
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    color_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (brdf_queue.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected transfer on result channel");
        end else begin
          want = brdf_queue.pop_front();
          if (rsp_if.reflect_red !== want.red || rsp_if.reflect_green !== want.green ||
              rsp_if.reflect_blue !== want.blue) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch exp %h %h %h got %h %h %h", want.red, want.green,
                       want.blue, rsp_if.reflect_red, rsp_if.reflect_green,
                       rsp_if.reflect_blue);
          end
        end
      end
    end
  end

  initial begin
    mismatch_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    kd_reg = '{3{16'd0}};
    ks_reg = '{3{16'd0}};
    shine_reg = pbe_pkg::SHINE_RESET;
    req_if.valid = 1'b0;
    {req_if.in_dir_x, req_if.in_dir_y, req_if.in_dir_z} = '0;
    {req_if.out_dir_x, req_if.out_dir_y, req_if.out_dir_z} = '0;
    {req_if.normal_x, req_if.normal_y, req_if.normal_z} = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = 3'd0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    build_tables();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_ray(axis_ray(16'sd16384, -16'sd16384, 16'sd16384));
    end_burst();
    drain_pipe();
    test_directed();
    test_backpressure();
    test_random();
    if (mismatch_cnt == 0 && brdf_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* phong_brdf_evaluate.f */
+incdir+design
design/pbe_pkg.sv
design/pbe_if.sv
design/pbe_geom.sv
design/pbe_pow.sv
design/pbe_shade.sv
design/phong_brdf_evaluate.sv
dv/tb_phong_brdf_evaluate.sv
